[hw/rtl/assert_macros.svh]
// assertion macros shared by the servo sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SRPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition now implies expression on the next edge
`define SRPS_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> expr) else $error(msg);

`endif

[hw/rtl/srps_pkg.sv]
// types, constants and helpers for the servo record and playback sequencer
package srps_pkg;

    localparam int MAX_POSITIONS = 16;
    localparam int CNT_W  = $clog2(MAX_POSITIONS + 1);
    localparam int IDX_W  = $clog2(MAX_POSITIONS + 2);
    localparam int ADDR_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

    localparam int WIDTH_W = 12;
    localparam int DWELL_W = 10;

    localparam logic [WIDTH_W-1:0] W_MIN  = 12'd600;
    localparam logic [WIDTH_W-1:0] W_MAX  = 12'd2400;
    localparam logic [WIDTH_W-1:0] W_HOME = 12'd1500;
    localparam logic [DWELL_W-1:0] DWELL_RESET = 10'd83;

    typedef enum logic [2:0] {
        F_TICK    = 3'd0,
        F_TRACK   = 3'd1,
        F_SAVE    = 3'd2,
        F_EXECUTE = 3'd3,
        F_CLEAR   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        CFG_HOME_A = 2'd0,
        CFG_HOME_B = 2'd1,
        CFG_HOME_C = 2'd2,
        CFG_DWELL  = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MOVE  = 2'd1,
        PH_DWELL = 2'd2
    } t_phase;

    typedef struct packed {
        logic [WIDTH_W-1:0] a;
        logic [WIDTH_W-1:0] b;
        logic [WIDTH_W-1:0] c;
    } t_pos;

    typedef struct packed {
        logic step;
        logic track;
        logic load;
    } t_axis_ctl;

    function automatic logic [WIDTH_W-1:0] clamp_w(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        r = v;
        if (v < W_MIN) begin
            r = W_MIN;
        end else if (v > W_MAX) begin
            r = W_MAX;
        end
        return r;
    endfunction

endpackage

[hw/rtl/servo_record_playback_stepper.sv]
// top level of the three-axis servo record and playback sequencer
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_func, i_width_a/b/c
//  out     | output    | o_out_valid / i_out_ready    | o_out_a/b/c, o_busy_res,
//          |           |                              | o_saved_count, o_save_refused
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  one item per cycle unless the output stalls; each result is registered at acceptance
//  the position memory is read every cycle at the next leg address, so its registered
//  read is hidden and a leg change may follow on every tick
//  synchronous reset restores home widths, empties the list and stops playback; no clearing pass
//  a stalled output holds the in channel until the result is taken
module servo_record_playback_stepper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_func,
    input  logic [srps_pkg::WIDTH_W-1:0] i_width_a,
    input  logic [srps_pkg::WIDTH_W-1:0] i_width_b,
    input  logic [srps_pkg::WIDTH_W-1:0] i_width_c,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [srps_pkg::WIDTH_W-1:0] o_out_a,
    output logic [srps_pkg::WIDTH_W-1:0] o_out_b,
    output logic [srps_pkg::WIDTH_W-1:0] o_out_c,
    output logic                         o_busy_res,
    output logic [srps_pkg::CNT_W-1:0]   o_saved_count,
    output logic                         o_save_refused,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [srps_pkg::WIDTH_W-1:0] i_cfg_data
);
    import srps_pkg::*;
    `include "assert_macros.svh"

    // configuration
    logic [WIDTH_W-1:0] r_home_a;
    logic [WIDTH_W-1:0] r_home_b;
    logic [WIDTH_W-1:0] r_home_c;
    logic [DWELL_W-1:0] r_dwell;

    // sequencer state
    t_phase             r_phase;
    t_phase             n_phase;
    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   n_index;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [DWELL_W-1:0] r_dcnt;
    logic [DWELL_W-1:0] n_dcnt;

    // output register
    logic               r_out_valid;
    logic [WIDTH_W-1:0] r_out_a;
    logic [WIDTH_W-1:0] r_out_b;
    logic [WIDTH_W-1:0] r_out_c;
    logic               r_out_busy;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_refused;

    logic               in_acc;
    logic               idle;
    t_func              func;
    logic               all_arrive;
    logic               e_tick;
    logic               e_move_done;
    logic               e_dwell_set;
    logic               e_dwell_end;
    logic               e_leg;
    logic               e_exec;
    logic               e_save;
    logic               refused;
    logic [DWELL_W-1:0] dcnt_dec;
    logic [IDX_W-1:0]   leg_p;
    logic               leg_store;
    logic               leg_home;
    logic               load_home;
    logic               load_mem;
    t_pos               cur_next;
    t_pos               mem_rd;
    t_pos               load_pos;
    t_axis_ctl          ctl;
    logic               arr_a;
    logic               arr_b;
    logic               arr_c;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign idle        = (r_phase == PH_IDLE);
    assign func        = t_func'(i_func);
    assign all_arrive  = arr_a && arr_b && arr_c;

    // event decode
    always_comb begin
        e_tick      = in_acc && (func == F_TICK);
        e_move_done = e_tick && (r_phase == PH_MOVE) && all_arrive;
        e_dwell_set = e_move_done && (r_dwell != '0);
        dcnt_dec    = (r_dcnt != '0) ? (r_dcnt - DWELL_W'(1)) : r_dcnt;
        e_dwell_end = e_tick && (r_phase == PH_DWELL) && (dcnt_dec == '0);
        e_leg       = (e_move_done && (r_dwell == '0)) || e_dwell_end;
        e_exec      = in_acc && (func == F_EXECUTE) && idle;
        e_save      = in_acc && (func == F_SAVE) && idle
                      && (r_count < CNT_W'(MAX_POSITIONS));
        refused     = in_acc && (func == F_SAVE) && idle
                      && (r_count >= CNT_W'(MAX_POSITIONS));
        leg_p       = r_index + IDX_W'(1);
        leg_store   = (leg_p <= IDX_W'(r_count)) && (leg_p <= IDX_W'(MAX_POSITIONS));
        leg_home    = !leg_store && (leg_p == (IDX_W'(r_count) + IDX_W'(1)));
    end

    // playback phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (e_exec) begin
                    n_phase = PH_MOVE;
                end
            end
            PH_MOVE: begin
                if (e_dwell_set) begin
                    n_phase = PH_DWELL;
                end else if (e_leg) begin
                    n_phase = (leg_store || leg_home) ? PH_MOVE : PH_IDLE;
                end
            end
            PH_DWELL: begin
                if (e_leg) begin
                    n_phase = (leg_store || leg_home) ? PH_MOVE : PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // sequencer datapath
    always_comb begin
        n_index = r_index;
        n_count = r_count;
        n_dcnt  = r_dcnt;
        if (e_exec) begin
            n_index = '0;
            n_dcnt  = '0;
        end else if (e_leg) begin
            n_index = (leg_store || leg_home) ? leg_p : '0;
        end
        if (e_dwell_set) begin
            n_dcnt = r_dwell;
        end else if (e_tick && (r_phase == PH_DWELL)) begin
            n_dcnt = dcnt_dec;
        end
        if (e_save) begin
            n_count = r_count + CNT_W'(1);
        end else if (in_acc && (func == F_CLEAR) && idle) begin
            n_count = '0;
        end
        load_home = e_exec || (e_leg && leg_home);
        load_mem  = e_leg && leg_store;
        if (load_mem) begin
            load_pos = mem_rd;
        end else begin
            load_pos.a = clamp_w(r_home_a);
            load_pos.b = clamp_w(r_home_b);
            load_pos.c = clamp_w(r_home_c);
        end
        ctl.step  = e_tick && (r_phase == PH_MOVE);
        ctl.track = in_acc && (func == F_TRACK) && idle;
        ctl.load  = load_home || load_mem;
    end

    // the read address follows the next index, so the entry for the following leg
    // is already registered when it is needed; the list never changes during playback
    srps_store u_store (
        .i_clk   (i_clk),
        .i_we    (e_save),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (cur_next),
        .i_raddr (n_index[ADDR_W-1:0]),
        .o_rdata (mem_rd)
    );

    srps_axis u_axis_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_track_w (i_width_a),
        .i_load_w  (load_pos.a),
        .o_next    (cur_next.a),
        .o_arrive  (arr_a)
    );

    srps_axis u_axis_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_track_w (i_width_b),
        .i_load_w  (load_pos.b),
        .o_next    (cur_next.b),
        .o_arrive  (arr_b)
    );

    srps_axis u_axis_c (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_track_w (i_width_c),
        .i_load_w  (load_pos.c),
        .o_next    (cur_next.c),
        .o_arrive  (arr_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_a <= W_HOME;
            r_home_b <= W_HOME;
            r_home_c <= W_HOME;
            r_dwell  <= DWELL_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_HOME_A: r_home_a <= i_cfg_data;
                CFG_HOME_B: r_home_b <= i_cfg_data;
                CFG_HOME_C: r_home_c <= i_cfg_data;
                CFG_DWELL:  r_dwell  <= i_cfg_data[DWELL_W-1:0];
                default:    r_dwell  <= r_dwell;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_index     <= '0;
            r_count     <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_index <= n_index;
            r_count <= n_count;
            r_dcnt  <= n_dcnt;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_a       <= cur_next.a;
            r_out_b       <= cur_next.b;
            r_out_c       <= cur_next.c;
            r_out_busy    <= (n_phase != PH_IDLE);
            r_out_count   <= n_count;
            r_out_refused <= refused;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_a        = r_out_a;
    assign o_out_b        = r_out_b;
    assign o_out_c        = r_out_c;
    assign o_busy_res     = r_out_busy;
    assign o_saved_count  = r_out_count;
    assign o_save_refused = r_out_refused;

    `SRPS_ASSERT(a_count_max, (r_count <= CNT_W'(MAX_POSITIONS)), "saved count beyond capacity")
    `SRPS_ASSERT(a_leg_range, (idle || (r_index <= (IDX_W'(r_count) + IDX_W'(1)))), "leg index past final home leg")
    `SRPS_ASSERT(a_refused_full, (!(r_out_valid && r_out_refused) || (r_count == CNT_W'(MAX_POSITIONS))), "save refused with room left")
    `SRPS_ASSERT_NEXT(a_result_follows, in_acc, r_out_valid, "accepted item gave no result")

endmodule

[hw/rtl/srps_store.sv]
// position memory: one write port, one registered read port
module srps_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [srps_pkg::ADDR_W-1:0] i_waddr,
    input  srps_pkg::t_pos              i_wdata,
    input  logic [srps_pkg::ADDR_W-1:0] i_raddr,
    output srps_pkg::t_pos              o_rdata
);
    import srps_pkg::*;

    t_pos r_mem [MAX_POSITIONS];
    t_pos r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/srps_axis.sv]
// one axis: current and target width, 1 us stepping toward the target
module srps_axis (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srps_pkg::t_axis_ctl          i_ctl,
    input  logic [srps_pkg::WIDTH_W-1:0] i_track_w,
    input  logic [srps_pkg::WIDTH_W-1:0] i_load_w,
    output logic [srps_pkg::WIDTH_W-1:0] o_next,
    output logic                         o_arrive
);
    import srps_pkg::*;

    logic [WIDTH_W-1:0] r_cur;
    logic [WIDTH_W-1:0] r_tgt;
    logic [WIDTH_W-1:0] n_cur;
    logic [WIDTH_W-1:0] n_tgt;
    logic [WIDTH_W-1:0] stepped;
    logic [WIDTH_W-1:0] track_c;

    always_comb begin
        stepped = r_cur;
        if (r_cur < r_tgt) begin
            stepped = r_cur + WIDTH_W'(1);
        end else if (r_cur > r_tgt) begin
            stepped = r_cur - WIDTH_W'(1);
        end
    end

    // arrival as seen after this tick's step
    assign o_arrive = (stepped == r_tgt);
    assign track_c  = clamp_w(i_track_w);

    always_comb begin
        n_cur = r_cur;
        n_tgt = r_tgt;
        if (i_ctl.track) begin
            n_cur = track_c;
            n_tgt = track_c;
        end else begin
            if (i_ctl.step) begin
                n_cur = stepped;
            end
            if (i_ctl.load) begin
                n_tgt = i_load_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= W_HOME;
            r_tgt <= W_HOME;
        end else begin
            r_cur <= n_cur;
            r_tgt <= n_tgt;
        end
    end

    assign o_next = n_cur;

endmodule

[dv/servo_record_playback_stepper_test.sv]
// self-checking testbench for the three-axis servo record and playback sequencer
`timescale 1ns / 100ps

module servo_record_playback_stepper_test;
    import srps_pkg::*;

    localparam logic [2:0] F_RSVD_5 = 3'd5;
    localparam logic [2:0] F_RSVD_6 = 3'd6;
    localparam logic [2:0] F_RSVD_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        logic [WIDTH_W-1:0] a;
        logic [WIDTH_W-1:0] b;
        logic [WIDTH_W-1:0] c;
        logic               busy;
        logic [CNT_W-1:0]   count;
        logic               refused;
    } t_servo_status;

    typedef struct packed {
        logic [2:0]         func;
        logic [WIDTH_W-1:0] wa;
        logic [WIDTH_W-1:0] wb;
        logic [WIDTH_W-1:0] wc;
        logic               typed;
        t_servo_status      want;
    } t_cmd_row;

    localparam t_servo_status NO_STATUS = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_func = F_TICK;
    logic [WIDTH_W-1:0] i_width_a = '0;
    logic [WIDTH_W-1:0] i_width_b = '0;
    logic [WIDTH_W-1:0] i_width_c = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [WIDTH_W-1:0] o_out_a;
    logic [WIDTH_W-1:0] o_out_b;
    logic [WIDTH_W-1:0] o_out_c;
    logic               o_busy_res;
    logic [CNT_W-1:0]   o_saved_count;
    logic               o_save_refused;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_HOME_A;
    logic [WIDTH_W-1:0] i_cfg_data = '0;

    servo_record_playback_stepper dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_width_a      (i_width_a),
        .i_width_b      (i_width_b),
        .i_width_c      (i_width_c),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_a        (o_out_a),
        .o_out_b        (o_out_b),
        .o_out_c        (o_out_c),
        .o_busy_res     (o_busy_res),
        .o_saved_count  (o_saved_count),
        .o_save_refused (o_save_refused),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer state as the testbench sees it
    logic [WIDTH_W-1:0] cur_w [3];
    logic [WIDTH_W-1:0] tgt_w [3];
    logic [WIDTH_W-1:0] home_cfg [3];
    logic [WIDTH_W-1:0] stored_w [MAX_POSITIONS][3];
    logic [DWELL_W-1:0] dwell_cfg;
    logic [DWELL_W-1:0] dwell_left;
    int                 saved_n;
    int                 leg_no;
    t_phase             play_phase;

    t_servo_status status_due [$];
    t_cmd_row      directed_rows [20];

    int  mismatches = 0;
    int  results_taken = 0;
    int  items_sent = 0;
    int  random_items = 0;
    int  playbacks = 0;
    int  refusals = 0;
    int  reg_writes = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;
    bit  hold_done = 1'b0;
    bit  counting = 1'b0;
    bit  quiet = 1'b0;

    function automatic logic [WIDTH_W-1:0] limit_width(input logic [WIDTH_W-1:0] w);
        return (w < W_MIN) ? W_MIN : ((w > W_MAX) ? W_MAX : w);
    endfunction

    function automatic void aim_home();
        for (int k = 0; k < 3; k++) begin
            tgt_w[k] = limit_width(home_cfg[k]);
        end
    endfunction

    // legs: 0 is the first home move, 1..n the saved positions, n+1 the home move back
    function automatic void begin_next_leg();
        leg_no++;
        if (leg_no >= 1 && leg_no <= saved_n && leg_no <= MAX_POSITIONS) begin
            for (int k = 0; k < 3; k++) begin
                tgt_w[k] = stored_w[leg_no - 1][k];
            end
            play_phase = PH_MOVE;
        end else if (leg_no == saved_n + 1) begin
            aim_home();
            play_phase = PH_MOVE;
        end else begin
            play_phase = PH_IDLE;
            leg_no = 0;
        end
    endfunction

    function automatic void advance_servo(input logic [2:0] f,
                                          input logic [WIDTH_W-1:0] wa, wb, wc,
                                          output t_servo_status st, output bit effective);
        logic [WIDTH_W-1:0] req [3];
        bit idle;
        bit reached;
        bit refused;
        req[0] = wa;
        req[1] = wb;
        req[2] = wc;
        idle = (play_phase == PH_IDLE);
        refused = 1'b0;
        effective = (f == F_TICK) ? !idle : ((f <= F_CLEAR) && idle);
        case (f)
            F_TICK: begin
                if (play_phase == PH_MOVE) begin
                    reached = 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        if (cur_w[k] < tgt_w[k]) begin
                            cur_w[k]++;
                        end else if (cur_w[k] > tgt_w[k]) begin
                            cur_w[k]--;
                        end
                        if (cur_w[k] != tgt_w[k]) reached = 1'b0;
                    end
                    if (reached) begin
                        if (dwell_cfg == 0) begin
                            begin_next_leg();
                        end else begin
                            dwell_left = dwell_cfg;
                            play_phase = PH_DWELL;
                        end
                    end
                end else if (play_phase == PH_DWELL) begin
                    if (dwell_left != 0) dwell_left--;
                    if (dwell_left == 0) begin_next_leg();
                end
            end
            F_TRACK: begin
                if (idle) begin
                    for (int k = 0; k < 3; k++) begin
                        cur_w[k] = limit_width(req[k]);
                        tgt_w[k] = cur_w[k];
                    end
                end
            end
            F_SAVE: begin
                if (idle) begin
                    if (saved_n < MAX_POSITIONS) begin
                        for (int k = 0; k < 3; k++) begin
                            stored_w[saved_n][k] = cur_w[k];
                        end
                        saved_n++;
                    end else begin
                        refused = 1'b1;
                        refusals++;
                    end
                end
            end
            F_EXECUTE: begin
                if (idle) begin
                    aim_home();
                    leg_no = 0;
                    dwell_left = '0;
                    play_phase = PH_MOVE;
                    playbacks++;
                end
            end
            F_CLEAR: begin
                if (idle) saved_n = 0;
            end
            default: begin
            end
        endcase
        st.a = cur_w[0];
        st.b = cur_w[1];
        st.c = cur_w[2];
        st.busy = (play_phase != PH_IDLE);
        st.count = CNT_W'(saved_n);
        st.refused = refused;
    endfunction

    task automatic offer_command(input logic [2:0] f, input logic [WIDTH_W-1:0] wa, wb, wc,
                                 input bit typed = 1'b0, input t_servo_status want = '0);
        t_servo_status predicted;
        bit effective;
        while (!quiet && hold_left == 0 && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_width_a <= wa;
        i_width_b <= wb;
        i_width_c <= wc;
        do @(posedge i_clk); while (!o_in_ready);
        advance_servo(f, wa, wb, wc, predicted, effective);
        status_due.push_back(typed ? want : predicted);
        items_sent++;
        if (counting && effective) random_items++;
        quiet = counting && random_items >= 100 && random_items < 200;
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (status_due.size() != 0);
    endtask

    task automatic program_registers(input logic [WIDTH_W-1:0] ha, hb, hc,
                                     input logic [DWELL_W-1:0] dw);
        logic [WIDTH_W-1:0] vals [4];
        t_cfg_reg idx;
        vals[0] = ha;
        vals[1] = hb;
        vals[2] = hc;
        vals[3] = WIDTH_W'(dw);
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_reg'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx)
                CFG_DWELL: dwell_cfg = vals[k][DWELL_W-1:0];
                default:   home_cfg[idx] = vals[k];
            endcase
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WIDTH_W-1:0] near_home(input int axis);
        int v;
        v = int'(limit_width(home_cfg[axis])) + int'($urandom_range(0, 40)) - 20;
        return WIDTH_W'(v);
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_home();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return W_MIN;
        if (r == 1) return W_MAX;
        return WIDTH_W'($urandom_range(W_MIN, W_MAX));
    endfunction

    task automatic run_to_idle(input bit chatter);
        logic [2:0] f;
        while (play_phase != PH_IDLE) begin
            f = F_TICK;
            if (chatter && $urandom_range(0, 99) < 15) f = 3'($urandom_range(F_TRACK, F_RSVD_7));
            offer_command(f, WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
        end
    endtask

    // clear, record n_pos positions near home, then play them back
    task automatic record_and_play(input int n_pos);
        for (int i = 0; i < n_pos; i++) begin
            if (i == 0) begin
                offer_command(F_CLEAR, WIDTH_W'($urandom), WIDTH_W'($urandom),
                              WIDTH_W'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                offer_command(($urandom_range(0, 1) == 0) ? F_TICK : F_RSVD_6,
                              WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
            end
            if (i == 0 || $urandom_range(0, 2) != 0) begin
                offer_command(F_TRACK, near_home(0), near_home(1), near_home(2));
            end
            offer_command(F_SAVE, WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
        end
        if (n_pos == 0) begin
            offer_command(F_CLEAR, WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
            offer_command(F_TRACK, near_home(0), near_home(1), near_home(2));
        end
        offer_command(F_EXECUTE, WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
        run_to_idle(1'b1);
    endtask

    // commands of any kind while idle, far widths included; never starts a playback
    task automatic scatter_noise();
        logic [2:0] f;
        repeat ($urandom_range(5, 20)) begin
            f = 3'($urandom_range(F_TICK, F_RSVD_7));
            if (f == F_EXECUTE) f = F_SAVE;
            offer_command(f, WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom));
        end
    endtask

    function automatic void compare_field(input string what, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_status();
        t_servo_status want;
        if (status_due.size() == 0) begin
            $display("%0t: result with nothing expected, a=%0d b=%0d c=%0d",
                     $time, o_out_a, o_out_b, o_out_c);
            mismatches++;
            return;
        end
        want = status_due.pop_front();
        compare_field("out_a", want.a, o_out_a);
        compare_field("out_b", want.b, o_out_b);
        compare_field("out_c", want.c, o_out_c);
        compare_field("busy_res", want.busy, o_busy_res);
        compare_field("saved_count", want.count, o_saved_count);
        compare_field("save_refused", want.refused, o_save_refused);
        results_taken++;
    endtask

    // result side: random stalls, one long hold-off while items keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_status();
            if (!hold_done && random_items >= 300 && i_in_valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("servo_record_playback_stepper test failed");
                $finish;
            end
        end
    end

    initial begin
        int round_no;
        int r;
        for (int k = 0; k < 3; k++) begin
            home_cfg[k] = W_HOME;
            cur_w[k] = W_HOME;
            tgt_w[k] = W_HOME;
        end
        dwell_cfg = DWELL_RESET;
        dwell_left = '0;
        saved_n = 0;
        leg_no = 0;
        play_phase = PH_IDLE;

        // reset settings; the saved position sits close to home to keep playback short
        directed_rows[0]  = '{F_TICK, 12'd0, 12'd0, 12'd0, 1'b1,
                              '{12'd1500, 12'd1500, 12'd1500, 1'b0, '0, 1'b0}};
        directed_rows[1]  = '{F_TRACK, 12'd0, 12'd4095, 12'd1500, 1'b1,
                              '{12'd600, 12'd2400, 12'd1500, 1'b0, '0, 1'b0}};
        directed_rows[2]  = '{F_TRACK, 12'd599, 12'd2401, 12'd600, 1'b1,
                              '{12'd600, 12'd2400, 12'd600, 1'b0, '0, 1'b0}};
        directed_rows[3]  = '{F_TRACK, 12'd601, 12'd2399, 12'd2400, 1'b1,
                              '{12'd601, 12'd2399, 12'd2400, 1'b0, '0, 1'b0}};
        directed_rows[4]  = '{F_RSVD_5, 12'd4095, 12'd0, 12'd4095, 1'b0, NO_STATUS};
        directed_rows[5]  = '{F_RSVD_6, 12'h555, 12'haaa, 12'h555, 1'b0, NO_STATUS};
        directed_rows[6]  = '{F_RSVD_7, 12'haaa, 12'h555, 12'haaa, 1'b0, NO_STATUS};
        directed_rows[7]  = '{F_SAVE, 12'd0, 12'd0, 12'd0, 1'b1,
                              '{12'd601, 12'd2399, 12'd2400, 1'b0, CNT_W'(1), 1'b0}};
        directed_rows[8]  = '{F_CLEAR, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[9]  = '{F_TRACK, 12'd1497, 12'd1503, 12'd1500, 1'b0, NO_STATUS};
        directed_rows[10] = '{F_SAVE, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[11] = '{F_TRACK, 12'd1500, 12'd1500, 12'd1500, 1'b0, NO_STATUS};
        directed_rows[12] = '{F_EXECUTE, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[13] = '{F_TRACK, 12'd4095, 12'd0, 12'd2000, 1'b0, NO_STATUS};
        directed_rows[14] = '{F_SAVE, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[15] = '{F_EXECUTE, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[16] = '{F_CLEAR, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[17] = '{F_RSVD_5, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        // home leg from home: zero-length move, seen as reached on the first tick
        directed_rows[18] = '{F_TICK, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};
        directed_rows[19] = '{F_TICK, 12'd0, 12'd0, 12'd0, 1'b0, NO_STATUS};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            offer_command(directed_rows[n].func, directed_rows[n].wa, directed_rows[n].wb,
                          directed_rows[n].wc, directed_rows[n].typed, directed_rows[n].want);
        end
        run_to_idle(1'b0);
        settle();

        // extreme home widths: a moderate dwell first, then zero dwell
        program_registers(W_MIN, W_MAX, W_MIN, 10'd20);
        record_and_play(1);
        settle();
        program_registers(W_MAX, W_MIN, W_MAX, 10'd0);
        record_and_play(3);
        settle();

        counting = 1'b1;
        round_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 14);
            if (round_no > 0 && r < 4) begin
                settle();
                r = $urandom_range(0, 99);
                program_registers(pick_home(), pick_home(), pick_home(),
                                  (r < 25) ? 10'd0 :
                                  (r < 85) ? DWELL_W'($urandom_range(1, 3)) :
                                             DWELL_W'($urandom_range(4, 40)));
                r = $urandom_range(4, 14);
            end
            if (round_no == 0 || r == 14) begin
                // fill the memory and try a few saves beyond it
                record_and_play(MAX_POSITIONS + $urandom_range(1, 3));
            end else if (r >= 11) begin
                scatter_noise();
            end else begin
                record_and_play($urandom_range(0, 4));
            end
            round_no++;
        end
        settle();
        repeat (8) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d playbacks, %0d refused saves",
                 items_sent, results_taken, playbacks, refusals);
        $display("%0d register writes over %0d random rounds, %0d mismatches",
                 reg_writes, round_no, mismatches);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("servo_record_playback_stepper test passed");
        end else begin
            $display("servo_record_playback_stepper test failed");
        end
        $finish;
    end

endmodule
